// ----- rtl/core/arcm_pkg.sv -----
// Shared types and constants for the regular conversion manager.
`timescale 1ns / 1ps

package arcm_pkg;

    localparam int SLOTS_DEFAULT = 4;

    localparam logic [15:0] EOC_STATUS_MIN = 16'h0002;

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_EXECUTE  = 3'd1,
        OP_READ     = 3'd2,
        OP_ENABLE   = 3'd3,
        OP_DISABLE  = 3'd4
    } arcm_op_t;

    typedef enum logic [1:0] {
        MGR_STOPPED = 2'd0,
        MGR_START   = 2'd1,
        MGR_ONGOING = 2'd2,
        MGR_DATA    = 2'd3
    } mgr_state_t;

    typedef struct packed {
        logic       load;
        logic       do_register;
        logic       do_read;
        logic       latch_held;
        logic       start_conv;
        logic       clear_flags;
        mgr_state_t state_next;
    } arcm_cmd_t;

    typedef struct packed {
        logic eoc_seen;
        logic read_hit;
    } arcm_status_t;

endpackage

// ----- rtl/core/arcm_ctrl.sv -----
// Manager state machine and handshake control.
`timescale 1ns / 1ps

module arcm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_operation,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  arcm_pkg::arcm_status_t status,
    output arcm_pkg::arcm_cmd_t   cmd
);
    import arcm_pkg::*;

    mgr_state_t state_reg;
    mgr_state_t state_next;
    mgr_state_t state_calc;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= MGR_STOPPED;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        s_ready = !out_valid_reg || m_ready;
        accept  = s_valid && s_ready;

        state_calc      = state_reg;
        cmd             = '0;
        cmd.load        = accept;

        case (arcm_op_t'(s_operation))
            OP_REGISTER: begin
                cmd.do_register = 1'b1;
            end
            OP_EXECUTE: begin
                if (state_reg == MGR_ONGOING && status.eoc_seen) begin
                    cmd.clear_flags = 1'b1;
                    state_calc      = MGR_DATA;
                end else if (state_reg == MGR_START || state_reg == MGR_DATA) begin
                    cmd.start_conv = 1'b1;
                    state_calc     = MGR_ONGOING;
                end
            end
            OP_READ: begin
                cmd.do_read    = 1'b1;
                cmd.latch_held = status.read_hit && (state_reg == MGR_DATA);
            end
            OP_ENABLE: begin
                if (state_reg == MGR_STOPPED) begin
                    state_calc = MGR_START;
                end
            end
            OP_DISABLE: begin
                if (state_reg == MGR_DATA || state_reg == MGR_ONGOING) begin
                    state_calc = MGR_STOPPED;
                end
            end
            default: begin
            end
        endcase

        cmd.state_next = state_calc;
        state_next     = accept ? state_calc : state_reg;

        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        m_valid = out_valid_reg;
    end

endmodule

// ----- rtl/core/arcm_datapath.sv -----
// Slot table, held result and output register of the conversion manager.
`timescale 1ns / 1ps

module arcm_datapath #(
    parameter int SLOTS = arcm_pkg::SLOTS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  arcm_pkg::arcm_cmd_t    cmd,
    output arcm_pkg::arcm_status_t status,
    input  logic [5:0]             s_channel,
    input  logic [3:0]             s_group,
    input  logic [15:0]            s_scan_end_flags,
    input  logic [1:0]             s_handle,
    input  logic [15:0]            s_adc_data,
    output logic [1:0]             m_handle_out,
    output logic                   m_register_failed,
    output logic                   m_start_conversion,
    output logic [3:0]             m_start_group,
    output logic                   m_clear_end_flags,
    output logic [5:0]             m_read_channel,
    output logic [15:0]            m_read_value,
    output logic [1:0]             m_manager_state
);
    import arcm_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0] slot_valid_reg;
    logic [5:0]       slot_channel_reg [SLOTS];
    logic [15:0]      held_value_reg;

    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] pick;
    logic             found;
    logic [IDX_W-1:0] rd_idx;
    logic [15:0]      read_value_calc;

    logic [1:0]       handle_out_reg;
    logic             failed_reg;
    logic             start_conv_reg;
    logic [3:0]       start_group_reg;
    logic             clear_reg;
    logic [5:0]       read_channel_reg;
    logic [15:0]      read_value_reg;
    logic [1:0]       state_out_reg;

    // Lowest matching slot wins; otherwise the lowest free slot.
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_valid_reg[i] && slot_channel_reg[i] == s_channel) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!slot_valid_reg[i]) begin
                free     = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
        pick  = hit ? hit_idx : free_idx;
        found = hit || free;

        rd_idx          = IDX_W'(s_handle);
        status.read_hit = (32'(s_handle) < SLOTS) && slot_valid_reg[rd_idx];
        status.eoc_seen = (s_scan_end_flags >= EOC_STATUS_MIN);

        read_value_calc = cmd.latch_held ? s_adc_data : held_value_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            held_value_reg <= '0;
        end else if (cmd.load) begin
            if (cmd.do_register && found) begin
                slot_valid_reg[pick] <= 1'b1;
            end
            held_value_reg <= read_value_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && cmd.do_register && found) begin
            slot_channel_reg[pick] <= s_channel;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            handle_out_reg   <= (cmd.do_register && found) ? 2'(pick) : 2'd0;
            failed_reg       <= cmd.do_register && !found;
            start_conv_reg   <= cmd.start_conv;
            start_group_reg  <= cmd.start_conv ? s_group : 4'd0;
            clear_reg        <= cmd.clear_flags;
            read_channel_reg <= (cmd.do_read && status.read_hit) ?
                                slot_channel_reg[rd_idx] : 6'd0;
            read_value_reg   <= cmd.do_read ? read_value_calc : 16'd0;
            state_out_reg    <= cmd.state_next;
        end
    end

    assign m_handle_out       = handle_out_reg;
    assign m_register_failed  = failed_reg;
    assign m_start_conversion = start_conv_reg;
    assign m_start_group      = start_group_reg;
    assign m_clear_end_flags  = clear_reg;
    assign m_read_channel     = read_channel_reg;
    assign m_read_value       = read_value_reg;
    assign m_manager_state    = state_out_reg;

endmodule

// ----- rtl/core/adc_regular_conversion_manager.sv -----
// Top level of the regular conversion manager.
// A result appears on the m_ channel in the cycle after the input transfer; the outputs are registered.
// Throughput: one item per cycle while m_ready is high; the single output register frees as m_ready takes it.
// The slot compare and state update settle within the accepting cycle.
// Reset (synchronous, active low) empties the slot table, stops the manager,
// zeroes the held value and drops m_valid.
`timescale 1ns / 1ps

module adc_regular_conversion_manager #(
    parameter int SLOTS = arcm_pkg::SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [5:0]  s_channel,
    input  logic [3:0]  s_group,
    input  logic [15:0] s_scan_end_flags,
    input  logic [1:0]  s_handle,
    input  logic [15:0] s_adc_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_handle_out,
    output logic        m_register_failed,
    output logic        m_start_conversion,
    output logic [3:0]  m_start_group,
    output logic        m_clear_end_flags,
    output logic [5:0]  m_read_channel,
    output logic [15:0] m_read_value,
    output logic [1:0]  m_manager_state
);
    import arcm_pkg::*;

    arcm_cmd_t    cmd;
    arcm_status_t status;

    arcm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    arcm_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_channel          (s_channel),
        .s_group            (s_group),
        .s_scan_end_flags   (s_scan_end_flags),
        .s_handle           (s_handle),
        .s_adc_data         (s_adc_data),
        .m_handle_out       (m_handle_out),
        .m_register_failed  (m_register_failed),
        .m_start_conversion (m_start_conversion),
        .m_start_group      (m_start_group),
        .m_clear_end_flags  (m_clear_end_flags),
        .m_read_channel     (m_read_channel),
        .m_read_value       (m_read_value),
        .m_manager_state    (m_manager_state)
    );

endmodule

// ----- rtl/core/arcm_checker.sv -----
// Port-level assertions for the regular conversion manager, with bind.
`timescale 1ns / 1ps

module arcm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_start_conversion,
    input logic        m_clear_end_flags,
    input logic [15:0] m_read_value,
    input logic [1:0]  m_manager_state
);
    import arcm_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value)
                                && $stable(m_manager_state))
        else $error("stalled result changed");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("input transfer gave no result");

    a_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_start_conversion |-> m_manager_state == MGR_ONGOING
                                          && !m_clear_end_flags)
        else $error("start pulse outside ongoing state");

    a_clear_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clear_end_flags |-> m_manager_state == MGR_DATA)
        else $error("clear pulse outside data state");

endmodule

bind adc_regular_conversion_manager arcm_checker u_arcm_checker (.*);

// ----- tb/adc_regular_conversion_manager_tb.sv -----
// Self-checking testbench for the regular conversion manager: queued driver, monitor, predictor.
`timescale 1ns / 1ps

module adc_regular_conversion_manager_tb;

    import arcm_pkg::*;

    localparam int SLOT_COUNT    = SLOTS_DEFAULT;
    localparam int PHASE_ITEMS   = 230;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct {
        logic [2:0]  op;
        logic [5:0]  channel;
        logic [3:0]  group;
        logic [15:0] flags;
        logic [1:0]  handle;
        logic [15:0] adc_data;
    } mgr_cmd_t;

    typedef struct {
        logic [1:0]  handle_out;
        logic        register_failed;
        logic        start_conversion;
        logic [3:0]  start_group;
        logic        clear_end_flags;
        logic [5:0]  read_channel;
        logic [15:0] read_value;
        logic [1:0]  manager_state;
    } mgr_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_operation = 3'd0;
    logic [5:0]  s_channel = 6'd0;
    logic [3:0]  s_group = 4'd0;
    logic [15:0] s_scan_end_flags = 16'd0;
    logic [1:0]  s_handle = 2'd0;
    logic [15:0] s_adc_data = 16'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_handle_out;
    logic        m_register_failed;
    logic        m_start_conversion;
    logic [3:0]  m_start_group;
    logic        m_clear_end_flags;
    logic [5:0]  m_read_channel;
    logic [15:0] m_read_value;
    logic [1:0]  m_manager_state;

    adc_regular_conversion_manager uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_channel          (s_channel),
        .s_group            (s_group),
        .s_scan_end_flags   (s_scan_end_flags),
        .s_handle           (s_handle),
        .s_adc_data         (s_adc_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_handle_out       (m_handle_out),
        .m_register_failed  (m_register_failed),
        .m_start_conversion (m_start_conversion),
        .m_start_group      (m_start_group),
        .m_clear_end_flags  (m_clear_end_flags),
        .m_read_channel     (m_read_channel),
        .m_read_value       (m_read_value),
        .m_manager_state    (m_manager_state)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    mgr_cmd_t    pending_cmds[$];
    mgr_result_t expected_results[$];
    mgr_cmd_t    cmd_on_bus;

    // predictor's copy of the manager
    logic        slot_used [SLOT_COUNT];
    logic [5:0]  slot_chan [SLOT_COUNT];
    mgr_state_t  ctrl_state;
    logic [15:0] held_sample;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int reg_fail_count = 0;
    int scan_start_count = 0;
    int latch_count = 0;

    function automatic mgr_result_t conv_manager_step(mgr_cmd_t c);
        mgr_result_t r;
        int pick;
        r = '{default: '0};
        case (c.op)
            OP_REGISTER: begin
                pick = -1;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!slot_used[i]) begin
                        if (pick < 0) pick = i;
                    end else if (slot_chan[i] == c.channel) begin
                        pick = i;
                        break;
                    end
                end
                if (pick >= 0) begin
                    slot_used[pick] = 1'b1;
                    slot_chan[pick] = c.channel;
                    r.handle_out = pick[1:0];
                end else begin
                    r.register_failed = 1'b1;
                    reg_fail_count++;
                end
            end
            OP_EXECUTE: begin
                if (ctrl_state == MGR_ONGOING && c.flags >= EOC_STATUS_MIN) begin
                    r.clear_end_flags = 1'b1;
                    ctrl_state = MGR_DATA;
                end else if (ctrl_state == MGR_START || ctrl_state == MGR_DATA) begin
                    r.start_conversion = 1'b1;
                    r.start_group = c.group;
                    ctrl_state = MGR_ONGOING;
                    scan_start_count++;
                end
            end
            OP_READ: begin
                if (slot_used[c.handle]) begin
                    r.read_channel = slot_chan[c.handle];
                    if (ctrl_state == MGR_DATA) begin
                        held_sample = c.adc_data;
                        latch_count++;
                    end
                end
                r.read_value = held_sample;
            end
            OP_ENABLE: begin
                if (ctrl_state == MGR_STOPPED) ctrl_state = MGR_START;
            end
            OP_DISABLE: begin
                if (ctrl_state == MGR_DATA || ctrl_state == MGR_ONGOING)
                    ctrl_state = MGR_STOPPED;
            end
            default: ;
        endcase
        r.manager_state = ctrl_state;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // driver: a new command is loaded only when the bus is free or the last one transferred
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(conv_manager_step(cmd_on_bus));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_on_bus = pending_cmds.pop_front();
                    s_operation <= cmd_on_bus.op;
                    s_channel <= cmd_on_bus.channel;
                    s_group <= cmd_on_bus.group;
                    s_scan_end_flags <= cmd_on_bus.flags;
                    s_handle <= cmd_on_bus.handle;
                    s_adc_data <= cmd_on_bus.adc_data;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        mgr_result_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    error_count++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("handle_out", e.handle_out, m_handle_out);
                    check_field("register_failed", e.register_failed, m_register_failed);
                    check_field("start_conversion", e.start_conversion, m_start_conversion);
                    check_field("start_group", e.start_group, m_start_group);
                    check_field("clear_end_flags", e.clear_end_flags, m_clear_end_flags);
                    check_field("read_channel", e.read_channel, m_read_channel);
                    check_field("read_value", e.read_value, m_read_value);
                    check_field("manager_state", e.manager_state, m_manager_state);
                    checked_count++;
                end
            end
        end
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    function automatic mgr_cmd_t make_cmd(logic [2:0] op, logic [5:0] ch, logic [3:0] grp,
                                          logic [15:0] flg, logic [1:0] hnd, logic [15:0] dat);
        mgr_cmd_t c;
        c.op = op;
        c.channel = ch;
        c.group = grp;
        c.flags = flg;
        c.handle = hnd;
        c.adc_data = dat;
        return c;
    endfunction

    function automatic mgr_cmd_t random_cmd(logic [2:0] op);
        logic [5:0] known_ch [4];
        logic [15:0] flg;
        known_ch = '{6'd0, 6'd63, 6'd21, 6'd42};
        // many small status words so the end-of-scan threshold is hit from both sides
        flg = ($urandom_range(99) < 40) ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
        return make_cmd(op,
                        ($urandom_range(1) != 0) ? known_ch[$urandom_range(3)]
                                                 : 6'($urandom_range(63)),
                        4'($urandom_range(15)), flg, 2'($urandom_range(3)),
                        16'($urandom_range(65535)));
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
    endtask

    initial begin
        int send_pct [4];
        int recv_pct [4];
        int pushed;
        int r;
        mgr_cmd_t c;
        send_pct = '{0, 59, 0, 15};
        recv_pct = '{0, 0, 59, 15};

        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_used[i] = 1'b0;
            slot_chan[i] = '0;
        end
        ctrl_state = MGR_STOPPED;
        held_sample = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty-slot read, stopped-state no-ops, table fill and overflow
        pending_cmds.push_back(make_cmd(OP_READ, 6'd0, 4'd0, 16'd0, 2'd3, 16'hFFFF));
        pending_cmds.push_back(make_cmd(OP_EXECUTE, 6'd0, 4'd15, 16'hFFFF, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_DISABLE, 6'd0, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_REGISTER, 6'd0, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_REGISTER, 6'd63, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_REGISTER, 6'd0, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_REGISTER, 6'd21, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_REGISTER, 6'd42, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_REGISTER, 6'd7, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_REGISTER, 6'd63, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_READ, 6'd0, 4'd0, 16'd0, 2'd0, 16'h1234));
        // directed: full controller cycle
        pending_cmds.push_back(make_cmd(OP_ENABLE, 6'd0, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_ENABLE, 6'd0, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_READ, 6'd0, 4'd0, 16'd0, 2'd1, 16'h5555));
        pending_cmds.push_back(make_cmd(OP_EXECUTE, 6'd0, 4'd15, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_EXECUTE, 6'd0, 4'd3, 16'd1, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_EXECUTE, 6'd0, 4'd3, 16'd2, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_READ, 6'd0, 4'd0, 16'd0, 2'd1, 16'hFFFF));
        pending_cmds.push_back(make_cmd(OP_EXECUTE, 6'd0, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_EXECUTE, 6'd0, 4'd0, 16'hFFFF, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_READ, 6'd0, 4'd0, 16'd0, 2'd2, 16'hA5A5));
        pending_cmds.push_back(make_cmd(OP_DISABLE, 6'd0, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_ENABLE, 6'd0, 4'd0, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_EXECUTE, 6'd0, 4'd9, 16'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_DISABLE, 6'd0, 4'd0, 16'd0, 2'd0, 16'd0));
        for (int k = 5; k < 8; k++)
            pending_cmds.push_back(random_cmd(3'(k)));

        for (int ph = 0; ph < 4; ph++) begin
            // sender holds off until the block has delivered everything
            wait_idle();
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            pushed = 0;
            while (pushed < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 15) begin
                    // well-formed scan: start, wait for end of scan, read out, maybe stop
                    pending_cmds.push_back(random_cmd(OP_ENABLE));
                    pending_cmds.push_back(random_cmd(OP_EXECUTE));
                    c = random_cmd(OP_EXECUTE);
                    c.flags = 16'($urandom_range(65535, 2));
                    pending_cmds.push_back(c);
                    pending_cmds.push_back(random_cmd(OP_READ));
                    pending_cmds.push_back(random_cmd(OP_READ));
                    pending_cmds.push_back(random_cmd(($urandom_range(1) != 0) ? OP_DISABLE
                                                                               : OP_EXECUTE));
                    pushed += 6;
                end else if (r < 97) begin
                    r = $urandom_range(99);
                    if (r < 10)      c = random_cmd(OP_REGISTER);
                    else if (r < 45) c = random_cmd(OP_EXECUTE);
                    else if (r < 75) c = random_cmd(OP_READ);
                    else if (r < 88) c = random_cmd(OP_ENABLE);
                    else             c = random_cmd(OP_DISABLE);
                    pending_cmds.push_back(c);
                    pushed++;
                end else begin
                    pending_cmds.push_back(random_cmd(3'($urandom_range(7, 5))));
                    pushed++;
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d commands over four handshake pacing phases, %0d results checked.",
                 accepted_count, checked_count);
        $display("Saw %0d failed registrations, %0d scan starts, %0d latched reads.",
                 reg_fail_count, scan_start_count, latch_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/arcm_pkg.sv
rtl/core/arcm_ctrl.sv
rtl/core/arcm_datapath.sv
rtl/core/adc_regular_conversion_manager.sv
rtl/core/arcm_checker.sv
tb/adc_regular_conversion_manager_tb.sv
